@@ hw/rtl/assert_macros.svh @@
// assertion macros used by glb_container_validator.sv
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds in the same cycle as its trigger
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// property holds in the cycle after its trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/glbv_pkg.sv @@
// types and constants of the glb container validator
// no dependencies
`default_nettype none
package glbv_pkg;

    localparam logic [31:0] GLB_MAGIC     = 32'h46546C67;
    localparam logic [31:0] GLB_JSON      = 32'h4E4F534A;
    localparam logic [31:0] GLB_BIN       = 32'h004E4942;
    localparam logic [31:0] GLB_VERSION   = 32'd2;
    localparam logic [31:0] HDR_BYTES     = 32'd12;
    localparam logic [31:0] MAGIC_END     = 32'd4;
    localparam logic [31:0] VERSION_END   = 32'd8;
    localparam logic [31:0] CHDR_BYTES    = 32'd8;
    localparam logic [31:0] CHDR_LEN_DONE = 32'd4;
    localparam logic [7:0]  OPEN_BRACE    = 8'h7B;

    // status codes, first failing check wins
    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_SMALL   = 4'd1;
    localparam logic [3:0] ST_MAGIC   = 4'd2;
    localparam logic [3:0] ST_VERSION = 4'd3;
    localparam logic [3:0] ST_LENGTH  = 4'd4;
    localparam logic [3:0] ST_CHDR    = 4'd5;
    localparam logic [3:0] ST_PAYLOAD = 4'd6;
    localparam logic [3:0] ST_ALIGN   = 4'd7;
    localparam logic [3:0] ST_DUPJSON = 4'd8;
    localparam logic [3:0] ST_TYPE    = 4'd9;
    localparam logic [3:0] ST_NOJSON  = 4'd10;
    localparam logic [3:0] ST_NOBIN   = 4'd11;
    localparam logic [3:0] ST_NOTOBJ  = 4'd12;

    localparam logic [1:0] CLS_OK      = 2'd0;
    localparam logic [1:0] CLS_INVALID = 2'd1;
    localparam logic [1:0] CLS_INCOMP  = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_CHDR,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } in_item_t;

    // packed so that status_code sits in the lowest bits
    typedef struct packed {
        logic [31:0] json_length;
        logic [31:0] json_offset;
        logic [1:0]  status_class;
        logic [3:0]  status_code;
    } result_t;

    function automatic logic [1:0] class_of(input logic [3:0] code);
        logic [1:0] cls;
        case (code) inside
            ST_OK:                       cls = CLS_OK;
            ST_VERSION, ST_TYPE, ST_NOBIN: cls = CLS_INCOMP;
            default:                     cls = CLS_INVALID;
        endcase
        return cls;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/glbv_in_stage.sv @@
// input register of the glb validator, one request deep
// depends on glbv_pkg
`default_nettype none
module glbv_in_stage (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,   // data_byte
    input  wire                 s_tlast,   // last_byte
    input  wire                 step_en,
    output logic                item_valid,
    output glbv_pkg::in_item_t  item
);

    logic               valid_reg, valid_next;
    glbv_pkg::in_item_t item_reg;

    // take a new request when empty or when the held one moves on
    assign s_tready = !valid_reg || step_en;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (step_en) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

@@ hw/rtl/glbv_core.sv @@
// per-byte parse state of the glb container and the final status decision
// depends on glbv_pkg
`default_nettype none
module glbv_core (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 step_en,
    input  glbv_pkg::in_item_t  item,
    output glbv_pkg::result_t   result
);

    logic [31:0]      bc_reg, bc_next;
    logic             ovr_reg, ovr_next;
    logic [31:0]      word_reg, word_next;
    logic [31:0]      decl_reg, decl_next;
    glbv_pkg::phase_t phase_reg, phase_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      held_reg, held_next;
    logic [3:0]       hdr_err_reg, hdr_err_next;
    logic [3:0]       pend_reg, pend_next;
    logic             seen_json_reg, seen_json_next;
    logic             seen_bin_reg, seen_bin_next;
    logic             first_ok_reg, first_ok_next;
    logic [31:0]      jstart_reg, jstart_next;
    logic [31:0]      jsize_reg, jsize_next;

    logic        do_begin;
    logic        chunk_fail;
    logic [31:0] room;
    logic [3:0]  code;

    always_comb begin
        bc_next        = bc_reg;
        ovr_next       = ovr_reg;
        word_next      = word_reg;
        decl_next      = decl_reg;
        phase_next     = phase_reg;
        rem_next       = rem_reg;
        held_next      = held_reg;
        hdr_err_next   = hdr_err_reg;
        pend_next      = pend_reg;
        seen_json_next = seen_json_reg;
        seen_bin_next  = seen_bin_reg;
        first_ok_next  = first_ok_reg;
        jstart_next    = jstart_reg;
        jsize_next     = jsize_reg;
        do_begin       = 1'b0;
        chunk_fail     = 1'b0;
        room           = '0;
        code           = glbv_pkg::ST_OK;
        result         = '0;

        if (ovr_reg || bc_reg == '1) begin
            ovr_next   = 1'b1;
            phase_next = glbv_pkg::PH_DONE;
        end else begin
            bc_next   = bc_reg + 32'd1;
            word_next = {item.data_byte, word_reg[31:8]};
            unique case (phase_reg)
                glbv_pkg::PH_HEADER: begin
                    if (bc_next == glbv_pkg::MAGIC_END && word_next != glbv_pkg::GLB_MAGIC) begin
                        hdr_err_next = glbv_pkg::ST_MAGIC;
                    end else if (bc_next == glbv_pkg::VERSION_END
                                 && word_next != glbv_pkg::GLB_VERSION
                                 && hdr_err_reg == glbv_pkg::ST_OK) begin
                        hdr_err_next = glbv_pkg::ST_VERSION;
                    end else if (bc_next == glbv_pkg::HDR_BYTES) begin
                        decl_next = word_next;
                        if (hdr_err_reg != glbv_pkg::ST_OK) begin
                            phase_next = glbv_pkg::PH_DONE;
                        end else begin
                            do_begin = 1'b1;
                        end
                    end
                end
                glbv_pkg::PH_CHDR: begin
                    rem_next = {28'd0, rem_reg[3:0] - 4'd1};
                    if (rem_next == glbv_pkg::CHDR_LEN_DONE) begin
                        held_next = word_next;
                    end else if (rem_next == '0) begin
                        // chunk header complete: word_next holds the type
                        room = decl_reg - bc_next;
                        if (bc_next > decl_reg || held_reg > room) begin
                            pend_next  = glbv_pkg::ST_PAYLOAD;
                            chunk_fail = 1'b1;
                        end else if (held_reg[1:0] != 2'b00) begin
                            pend_next  = glbv_pkg::ST_ALIGN;
                            chunk_fail = 1'b1;
                        end else if (word_next == glbv_pkg::GLB_JSON) begin
                            if (seen_json_reg) begin
                                pend_next  = glbv_pkg::ST_DUPJSON;
                                chunk_fail = 1'b1;
                            end else begin
                                seen_json_next = 1'b1;
                                jstart_next    = bc_next;
                                jsize_next     = held_reg;
                            end
                        end else if (word_next == glbv_pkg::GLB_BIN) begin
                            seen_bin_next = 1'b1;
                        end else begin
                            pend_next  = glbv_pkg::ST_TYPE;
                            chunk_fail = 1'b1;
                        end
                        if (chunk_fail) begin
                            phase_next = glbv_pkg::PH_DONE;
                        end else if (held_reg == '0) begin
                            do_begin = 1'b1;
                        end else begin
                            phase_next = glbv_pkg::PH_PAYLOAD;
                            rem_next   = held_reg;
                        end
                    end
                end
                glbv_pkg::PH_PAYLOAD: begin
                    if (seen_json_reg && jsize_reg != '0 && bc_reg == jstart_reg
                        && item.data_byte == glbv_pkg::OPEN_BRACE) begin
                        first_ok_next = 1'b1;
                    end
                    rem_next = rem_reg - 32'd1;
                    if (rem_next == '0) begin
                        do_begin = 1'b1;
                    end
                end
                glbv_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end

        // next chunk starts at the current byte count
        if (do_begin) begin
            if (bc_next >= decl_next) begin
                phase_next = glbv_pkg::PH_DONE;
            end else if (decl_next - bc_next < glbv_pkg::CHDR_BYTES) begin
                pend_next  = glbv_pkg::ST_CHDR;
                phase_next = glbv_pkg::PH_DONE;
            end else begin
                phase_next = glbv_pkg::PH_CHDR;
                rem_next   = glbv_pkg::CHDR_BYTES;
            end
        end

        // final decision in check order
        if (!ovr_next && bc_next < glbv_pkg::HDR_BYTES) begin
            code = glbv_pkg::ST_SMALL;
        end else if (hdr_err_next != glbv_pkg::ST_OK) begin
            code = hdr_err_next;
        end else if (ovr_next || decl_next != bc_next) begin
            code = glbv_pkg::ST_LENGTH;
        end else if (pend_next != glbv_pkg::ST_OK) begin
            code = pend_next;
        end else if (!seen_json_next) begin
            code = glbv_pkg::ST_NOJSON;
        end else if (!seen_bin_next) begin
            code = glbv_pkg::ST_NOBIN;
        end else if (!first_ok_next) begin
            code = glbv_pkg::ST_NOTOBJ;
        end
        result.status_code  = code;
        result.status_class = glbv_pkg::class_of(code);
        result.json_offset  = seen_json_next ? jstart_next : '0;
        result.json_length  = seen_json_next ? jsize_next : '0;

        // a finished file leaves everything as after reset
        if (item.last_byte) begin
            bc_next        = '0;
            ovr_next       = 1'b0;
            word_next      = '0;
            decl_next      = '0;
            phase_next     = glbv_pkg::PH_HEADER;
            rem_next       = '0;
            held_next      = '0;
            hdr_err_next   = glbv_pkg::ST_OK;
            pend_next      = glbv_pkg::ST_OK;
            seen_json_next = 1'b0;
            seen_bin_next  = 1'b0;
            first_ok_next  = 1'b0;
            jstart_next    = '0;
            jsize_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg        <= '0;
            ovr_reg       <= 1'b0;
            word_reg      <= '0;
            decl_reg      <= '0;
            phase_reg     <= glbv_pkg::PH_HEADER;
            rem_reg       <= '0;
            held_reg      <= '0;
            hdr_err_reg   <= glbv_pkg::ST_OK;
            pend_reg      <= glbv_pkg::ST_OK;
            seen_json_reg <= 1'b0;
            seen_bin_reg  <= 1'b0;
            first_ok_reg  <= 1'b0;
            jstart_reg    <= '0;
            jsize_reg     <= '0;
        end else if (step_en) begin
            bc_reg        <= bc_next;
            ovr_reg       <= ovr_next;
            word_reg      <= word_next;
            decl_reg      <= decl_next;
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            held_reg      <= held_next;
            hdr_err_reg   <= hdr_err_next;
            pend_reg      <= pend_next;
            seen_json_reg <= seen_json_next;
            seen_bin_reg  <= seen_bin_next;
            first_ok_reg  <= first_ok_next;
            jstart_reg    <= jstart_next;
            jsize_reg     <= jsize_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/glb_container_validator.sv @@
// top level of the glb container validator: input register, parser, result register
// depends on glbv_pkg, glbv_in_stage, glbv_core and assert_macros.svh
//
// The validator takes a binary glTF file one byte per request on the s_ side,
// with s_tlast on the final byte, and checks the container: the 12-byte
// header (magic, version 2, declared length equal to the byte count) and the
// chain of chunk headers (bounds against the declared length, 4-byte
// alignment, a single JSON chunk, known chunk types, JSON and BIN both
// present, JSON payload opening with a brace). One result request leaves on
// the m_ side after each final byte; it carries the first failing check's
// code, its class, and the offset and length of the JSON payload. A byte is
// accepted in every cycle unless a final byte waits for the result slot;
// the rate is set by the state update between the input register and the
// parse state. A final byte passes through the input register and then the
// result register before m_tvalid rises. A final byte waits only while an
// earlier result is still held and m_tready is low. After each result the
// parser is back in its reset state, ready for the next file.
`default_nettype none
`include "assert_macros.svh"
module glb_container_validator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tlast,   // last_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata    // [3:0] status_code, [5:4] status_class,
                                   // [37:6] json_offset, [69:38] json_length
);

    logic               item_valid;
    glbv_pkg::in_item_t item;
    glbv_pkg::result_t  step_result;
    logic               step_en;
    logic               res_load;

    logic               out_valid_reg, out_valid_next;
    glbv_pkg::result_t  out_data_reg;

    // a byte moves on unless it is a final byte and the result slot is full
    assign step_en  = item_valid && (!item.last_byte || !out_valid_reg || m_tready);
    assign res_load = step_en && item.last_byte;

    glbv_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .step_en    (step_en),
        .item_valid (item_valid),
        .item       (item)
    );

    glbv_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item),
        .result  (step_result)
    );

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    // a new result only follows a processed final byte
    `ASSERT_IMPLIES(a_result_from_last, aclk, aresetn, $rose(m_tvalid),
        $past(res_load))
    // a held result is never overwritten
    `ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, m_tvalid && !m_tready, !res_load)
    // class is zero exactly when the code is zero
    `ASSERT_IMPLIES(a_class_code, aclk, aresetn, m_tvalid,
        (out_data_reg.status_code == glbv_pkg::ST_OK) ==
        (out_data_reg.status_class == glbv_pkg::CLS_OK))

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// self-checking bench for glb_container_validator: streams whole glb files byte by byte
// depends on glbv_pkg for result and phase types, status codes and container constants
`timescale 1ns / 1ps
module tb_top;
    import glbv_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_BYTES = 750;
    localparam int TAIL_CYCLES  = 8;
    localparam int DIR_ROWS     = 24;

    // directed file recipes
    typedef enum logic [4:0] {
        K_ONE_BYTE, K_ELEVEN, K_HDR_ONLY, K_OK_MIN, K_OK_BIN_FIRST, K_MAGIC,
        K_MAGIC_VER, K_VERSION, K_VERSION_MAX, K_MAGIC_LEN, K_DECL_MAX, K_DECL_ZERO,
        K_CHDR, K_PAYLOAD, K_CHUNK_HUGE, K_ALIGN, K_ERR_AND_LEN, K_DUPJSON,
        K_TYPE, K_NOJSON, K_NOBIN, K_NOTOBJ, K_EMPTY_JSON, K_ZEROS
    } dir_kind_t;

    // pinned rows carry a hand-typed code and class, the rest rely on the predictor
    typedef struct packed {
        dir_kind_t  kind;
        logic       pinned;
        logic [3:0] code;
        logic [1:0] cls;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic        s_tlast;     // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;     // [3:0] status_code, [5:4] status_class,
                              // [37:6] json_offset, [69:38] json_length

    glb_container_validator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow of the container walker
    logic [31:0] nbytes;
    logic        sat_hit;
    logic [31:0] word_acc;
    logic [31:0] file_len;
    phase_t      walk_phase;
    logic [31:0] left_in_chunk;
    logic [31:0] chunk_len;
    logic [3:0]  hdr_fault;
    logic [3:0]  chunk_fault;
    logic        have_json;
    logic        have_bin;
    logic        brace_seen;
    logic [31:0] json_at;
    logic [31:0] json_len;

    result_t     reports_due[$];   // one report per final byte, oldest first
    logic [7:0]  fbuf[$];          // file under construction
    dir_row_t    dir_tab [DIR_ROWS];

    logic        pin_exp;
    logic [3:0]  pin_code;
    logic [1:0]  pin_cls;

    int          src_gap_pct;
    int          dst_stall_pct;
    int          sent_bytes;
    int          fault_cnt;
    int          cycles;
    result_t     got_rep;
    result_t     want_rep;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    task automatic walker_reset();
        nbytes        = '0;
        sat_hit       = 1'b0;
        word_acc      = '0;
        file_len      = '0;
        walk_phase    = PH_HEADER;
        left_in_chunk = '0;
        chunk_len     = '0;
        hdr_fault     = ST_OK;
        chunk_fault   = ST_OK;
        have_json     = 1'b0;
        have_bin      = 1'b0;
        brace_seen    = 1'b0;
        json_at       = '0;
        json_len      = '0;
    endtask

    // called on a chunk boundary
    task automatic walker_next_chunk();
        if (nbytes >= file_len) begin
            walk_phase = PH_DONE;
        end else if (file_len - nbytes < CHDR_BYTES) begin
            // not even room for a chunk header before the declared end
            chunk_fault = ST_CHDR;
            walk_phase  = PH_DONE;
        end else begin
            walk_phase    = PH_CHDR;
            left_in_chunk = CHDR_BYTES;
        end
    endtask

    task automatic walker_chunk_header(input logic [31:0] typ);
        logic [3:0] f;
        f = ST_OK;
        if (nbytes > file_len || chunk_len > file_len - nbytes) begin
            f = ST_PAYLOAD;
        end else if (chunk_len[1:0] != 2'b00) begin
            f = ST_ALIGN;
        end else if (typ == GLB_JSON && have_json) begin
            f = ST_DUPJSON;
        end else if (typ == GLB_JSON) begin
            have_json = 1'b1;
            json_at   = nbytes;
            json_len  = chunk_len;
        end else if (typ == GLB_BIN) begin
            have_bin = 1'b1;
        end else begin
            f = ST_TYPE;
        end
        if (f != ST_OK) begin
            chunk_fault = f;
            walk_phase  = PH_DONE;
        end else if (chunk_len == 0) begin
            walker_next_chunk();
        end else begin
            walk_phase    = PH_PAYLOAD;
            left_in_chunk = chunk_len;
        end
    endtask

    // advance the shadow by one accepted byte; a final byte queues a report
    task automatic predict_report(input logic [7:0] b, input logic lst);
        logic [31:0] at;
        logic [3:0]  c;
        result_t     rep;
        at = nbytes;
        if (sat_hit || nbytes == 32'hFFFF_FFFF) begin
            sat_hit    = 1'b1;
            walk_phase = PH_DONE;
        end else begin
            nbytes   = nbytes + 32'd1;
            word_acc = {b, word_acc[31:8]};
            case (walk_phase)
                PH_HEADER: begin
                    if (nbytes == MAGIC_END && word_acc != GLB_MAGIC) begin
                        hdr_fault = ST_MAGIC;
                    end else if (nbytes == VERSION_END && word_acc != GLB_VERSION
                                 && hdr_fault == ST_OK) begin
                        hdr_fault = ST_VERSION;
                    end else if (nbytes == HDR_BYTES) begin
                        file_len = word_acc;
                        if (hdr_fault != ST_OK) walk_phase = PH_DONE;
                        else walker_next_chunk();
                    end
                end
                PH_CHDR: begin
                    left_in_chunk = left_in_chunk - 32'd1;
                    if (left_in_chunk == CHDR_LEN_DONE) chunk_len = word_acc;
                    else if (left_in_chunk == 0) walker_chunk_header(word_acc);
                end
                PH_PAYLOAD: begin
                    // only the first byte of a non-empty json payload matters
                    if (have_json && json_len != 0 && at == json_at && b == OPEN_BRACE)
                        brace_seen = 1'b1;
                    left_in_chunk = left_in_chunk - 32'd1;
                    if (left_in_chunk == 0) walker_next_chunk();
                end
                default: ;
            endcase
        end

        if (lst) begin
            // first failing check in priority order
            if (!sat_hit && nbytes < HDR_BYTES) c = ST_SMALL;
            else if (hdr_fault != ST_OK) c = hdr_fault;
            else if (sat_hit || file_len != nbytes) c = ST_LENGTH;
            else if (chunk_fault != ST_OK) c = chunk_fault;
            else if (!have_json) c = ST_NOJSON;
            else if (!have_bin) c = ST_NOBIN;
            else if (!brace_seen) c = ST_NOTOBJ;
            else c = ST_OK;
            rep.status_code = c;
            case (c)
                ST_OK:                         rep.status_class = CLS_OK;
                ST_VERSION, ST_TYPE, ST_NOBIN: rep.status_class = CLS_INCOMP;
                default:                       rep.status_class = CLS_INVALID;
            endcase
            rep.json_offset = have_json ? json_at : 32'd0;
            rep.json_length = have_json ? json_len : 32'd0;
            if (pin_exp) begin
                rep.status_code  = pin_code;
                rep.status_class = pin_cls;
                pin_exp = 1'b0;
            end
            reports_due.insert(reports_due.size(), rep);
            walker_reset();
        end
    endtask

    // ---------------------------------------------------------------
    // file construction
    // ---------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        fbuf.insert(fbuf.size(), b);
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) add_byte(w[8*k +: 8]);
    endtask

    // 12-byte header, declared length patched later
    task automatic start_file(input logic [31:0] magic, input logic [31:0] ver);
        fbuf.delete();
        put_word(magic);
        put_word(ver);
        put_word(32'd0);
    endtask

    task automatic set_len(input logic [31:0] w);
        for (int k = 0; k < 4; k++) fbuf[8 + k] = w[8*k +: 8];
    endtask

    // chunk header plus payload; the length field may disagree with the payload
    task automatic put_chunk(input logic [31:0] len_field, input logic [31:0] typ,
                             input int nb, input logic [7:0] first);
        put_word(len_field);
        put_word(typ);
        for (int k = 0; k < nb; k++)
            add_byte(k == 0 ? first : 8'($urandom_range(255)));
    endtask

    task automatic put_body();
        put_chunk(32'd4, GLB_JSON, 4, OPEN_BRACE);
        put_chunk(32'd4, GLB_BIN, 4, 8'h00);
    endtask

    task automatic build_directed(input dir_kind_t k);
        start_file(GLB_MAGIC, GLB_VERSION);
        case (k)
            K_ONE_BYTE: begin
                fbuf.delete();
                add_byte(8'hFF);
            end
            K_ELEVEN:       void'(fbuf.pop_back());
            K_HDR_ONLY:     ;
            K_OK_MIN: begin
                put_chunk(32'd4, GLB_JSON, 4, OPEN_BRACE);
                put_chunk(32'd0, GLB_BIN, 0, 8'h00);
            end
            K_OK_BIN_FIRST: begin
                put_chunk(32'd8, GLB_BIN, 8, 8'hFF);
                put_chunk(32'd8, GLB_JSON, 8, OPEN_BRACE);
            end
            K_MAGIC: begin
                start_file(GLB_MAGIC ^ 32'd1, GLB_VERSION);
                put_body();
            end
            K_MAGIC_VER: begin
                start_file(32'd0, 32'd0);
                put_body();
            end
            K_VERSION: begin
                start_file(GLB_MAGIC, 32'd1);
                put_body();
            end
            K_VERSION_MAX: begin
                start_file(GLB_MAGIC, 32'hFFFF_FFFF);
                put_body();
            end
            K_MAGIC_LEN: begin
                start_file(~GLB_MAGIC, GLB_VERSION);
                put_body();
            end
            K_DECL_MAX, K_DECL_ZERO: put_body();
            K_CHDR: begin
                // four stray bytes after the last chunk, inside the declared length
                put_body();
                repeat (4) add_byte(8'($urandom_range(255)));
            end
            K_PAYLOAD: begin
                put_chunk(32'd64, GLB_JSON, 4, OPEN_BRACE);
                put_chunk(32'd4, GLB_BIN, 4, 8'h00);
            end
            K_CHUNK_HUGE: begin
                put_chunk(32'hFFFF_FFFF, GLB_JSON, 4, OPEN_BRACE);
                put_chunk(32'd4, GLB_BIN, 4, 8'h00);
            end
            K_ALIGN, K_ERR_AND_LEN: begin
                put_chunk(32'd5, GLB_JSON, 5, OPEN_BRACE);
                put_chunk(32'd4, GLB_BIN, 4, 8'h00);
            end
            K_DUPJSON: begin
                put_chunk(32'd4, GLB_JSON, 4, OPEN_BRACE);
                put_chunk(32'd4, GLB_JSON, 4, OPEN_BRACE);
                put_chunk(32'd4, GLB_BIN, 4, 8'h00);
            end
            K_TYPE: begin
                put_chunk(32'd4, GLB_JSON, 4, OPEN_BRACE);
                put_chunk(32'd4, 32'h2020_2020, 4, 8'h00);
                put_chunk(32'd4, GLB_BIN, 4, 8'h00);
            end
            K_NOJSON:       put_chunk(32'd4, GLB_BIN, 4, OPEN_BRACE);
            K_NOBIN:        put_chunk(32'd4, GLB_JSON, 4, OPEN_BRACE);
            K_NOTOBJ: begin
                put_chunk(32'd4, GLB_JSON, 4, 8'h5B);
                put_chunk(32'd4, GLB_BIN, 4, 8'h00);
            end
            K_EMPTY_JSON: begin
                put_chunk(32'd0, GLB_JSON, 0, 8'h00);
                put_chunk(32'd4, GLB_BIN, 4, 8'h00);
            end
            K_ZEROS: begin
                fbuf.delete();
                repeat (16) add_byte(8'h00);
            end
            default: ;
        endcase
        if (fbuf.size() >= 12) set_len(32'(fbuf.size()));
        case (k)
            K_DECL_MAX:                 set_len(32'hFFFF_FFFF);
            K_DECL_ZERO:                set_len(32'd0);
            K_MAGIC_LEN, K_ERR_AND_LEN: set_len(32'(fbuf.size() + 4));
            default: ;
        endcase
    endtask

    // mostly well-formed files with random content, some noise and damage
    task automatic build_random();
        int          nch;
        int          plen;
        int          r;
        int          idx;
        logic [31:0] typ;
        logic [31:0] lfield;
        logic [7:0]  first;
        if ($urandom_range(99) < 8) begin
            fbuf.delete();
            repeat ($urandom_range(40, 1)) add_byte(8'($urandom_range(255)));
        end else begin
            start_file($urandom_range(99) < 95 ? GLB_MAGIC : 32'($urandom),
                       $urandom_range(99) < 95 ? GLB_VERSION : 32'($urandom_range(4)));
            nch = $urandom_range(4);
            for (int c = 0; c < nch; c++) begin
                plen = 4 * $urandom_range(6);
                r = $urandom_range(99);
                if (c == 0 && r < 85) typ = GLB_JSON;
                else if (r < 6) typ = GLB_JSON;
                else if (r < 94) typ = GLB_BIN;
                else typ = 32'($urandom);
                lfield = 32'(plen);
                r = $urandom_range(99);
                if (r < 5) lfield = lfield + 32'($urandom_range(3, 1));
                else if (r < 7) lfield = 32'($urandom);
                first = (typ == GLB_JSON && $urandom_range(99) < 90)
                        ? OPEN_BRACE : 8'($urandom_range(255));
                put_chunk(lfield, typ, plen, first);
            end
            set_len(32'(fbuf.size()));
            r = $urandom_range(99);
            if (r < 5) set_len(32'(fbuf.size() + $urandom_range(8, 1)));
            else if (r < 8) set_len(32'(fbuf.size() - $urandom_range(8, 1)));
            else if (r < 10) set_len(32'($urandom));
        end
        // damage: a corrupted byte, a cut tail
        if ($urandom_range(99) < 6) begin
            idx = $urandom_range(fbuf.size() - 1);
            fbuf[idx] = fbuf[idx] ^ 8'($urandom_range(255, 1));
        end
        if ($urandom_range(99) < 5)
            repeat ($urandom_range(8, 1)) if (fbuf.size() > 1) void'(fbuf.pop_back());
    endtask

    // ---------------------------------------------------------------
    // input side: one byte request per call, entered and left at a falling edge
    // ---------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_bytes++;
        predict_report(b, lst);
        @(negedge aclk);
    endtask

    task automatic send_file();
        for (int i = 0; i < fbuf.size(); i++)
            push_byte(fbuf[i], i == fbuf.size() - 1);
    endtask

    // ---------------------------------------------------------------
    // output side: random back-pressure, checks at the rising edge
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_rep = m_tdata[69:0];
            if (reports_due.size() == 0) begin
                if (fault_cnt < 10)
                    $display("%0t: result with nothing expected: code %0d class %0d",
                             $realtime, got_rep.status_code, got_rep.status_class);
                fault_cnt++;
            end else begin
                want_rep = reports_due.pop_front();
                if (got_rep.status_code != want_rep.status_code
                    || got_rep.status_class != want_rep.status_class
                    || got_rep.json_offset != want_rep.json_offset
                    || got_rep.json_length != want_rep.json_length) begin
                    if (fault_cnt < 10) begin
                        $write("%0t: mismatch exp/act code %0d/%0d class %0d/%0d",
                               $realtime,
                               want_rep.status_code, got_rep.status_code,
                               want_rep.status_class, got_rep.status_class);
                        $display(" offset %h/%h length %h/%h",
                                 want_rep.json_offset, got_rep.json_offset,
                                 want_rep.json_length, got_rep.json_length);
                    end
                    fault_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        int mark;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        pin_exp       = 1'b0;
        pin_code      = ST_OK;
        pin_cls       = CLS_OK;
        sent_bytes    = 0;
        fault_cnt     = 0;
        cycles        = 0;
        src_gap_pct   = 15;
        dst_stall_pct = 87;
        walker_reset();

        dir_tab = '{
            '{K_ONE_BYTE,     1'b1, ST_SMALL,   CLS_INVALID},
            '{K_ELEVEN,       1'b1, ST_SMALL,   CLS_INVALID},
            '{K_HDR_ONLY,     1'b1, ST_NOJSON,  CLS_INVALID},
            '{K_OK_MIN,       1'b0, ST_OK,      CLS_OK},
            '{K_OK_BIN_FIRST, 1'b0, ST_OK,      CLS_OK},
            '{K_MAGIC,        1'b1, ST_MAGIC,   CLS_INVALID},
            '{K_MAGIC_VER,    1'b1, ST_MAGIC,   CLS_INVALID},
            '{K_VERSION,      1'b1, ST_VERSION, CLS_INCOMP},
            '{K_VERSION_MAX,  1'b1, ST_VERSION, CLS_INCOMP},
            '{K_MAGIC_LEN,    1'b1, ST_MAGIC,   CLS_INVALID},
            '{K_DECL_MAX,     1'b1, ST_LENGTH,  CLS_INVALID},
            '{K_DECL_ZERO,    1'b1, ST_LENGTH,  CLS_INVALID},
            '{K_CHDR,         1'b1, ST_CHDR,    CLS_INVALID},
            '{K_PAYLOAD,      1'b1, ST_PAYLOAD, CLS_INVALID},
            '{K_CHUNK_HUGE,   1'b1, ST_PAYLOAD, CLS_INVALID},
            '{K_ALIGN,        1'b1, ST_ALIGN,   CLS_INVALID},
            '{K_ERR_AND_LEN,  1'b1, ST_LENGTH,  CLS_INVALID},
            '{K_DUPJSON,      1'b1, ST_DUPJSON, CLS_INVALID},
            '{K_TYPE,         1'b1, ST_TYPE,    CLS_INCOMP},
            '{K_NOJSON,       1'b1, ST_NOJSON,  CLS_INVALID},
            '{K_NOBIN,        1'b1, ST_NOBIN,   CLS_INCOMP},
            '{K_NOTOBJ,       1'b1, ST_NOTOBJ,  CLS_INVALID},
            '{K_EMPTY_JSON,   1'b1, ST_NOTOBJ,  CLS_INVALID},
            '{K_ZEROS,        1'b1, ST_MAGIC,   CLS_INVALID}
        };

        // synchronous reset, released at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed files, under the first idling mix
        for (int row = 0; row < DIR_ROWS; row++) begin
            pin_exp  = dir_tab[row].pinned;
            pin_code = dir_tab[row].code;
            pin_cls  = dir_tab[row].cls;
            build_directed(dir_tab[row].kind);
            send_file();
        end

        // random files: sender light / receiver heavy, then swapped, then no idling
        for (int ph = 0; ph < 3; ph++) begin
            src_gap_pct   = (ph == 0) ? 15 : (ph == 1) ? 87 : 0;
            dst_stall_pct = (ph == 0) ? 87 : (ph == 1) ? 15 : 0;
            if (ph != 0) begin
                // hold off until every outstanding report has drained
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (reports_due.size() != 0);
            end
            mark = sent_bytes;
            while (sent_bytes - mark < RANDOM_BYTES / 3) begin
                build_random();
                send_file();
            end
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (reports_due.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (fault_cnt == 0 && reports_due.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
